// ===== hw/rtl/pwhc_pkg.sv =====
package pwhc_pkg;

  // Header layout
  localparam int unsigned HEADER_BYTES = 44;

  // Byte offsets that complete a checked or captured field
  localparam logic [5:0] POS_RIFF     = 6'd3;
  localparam logic [5:0] POS_CHUNK    = 6'd7;
  localparam logic [5:0] POS_WAVE     = 6'd11;
  localparam logic [5:0] POS_FMT      = 6'd15;
  localparam logic [5:0] POS_FMT_SIZE = 6'd19;
  localparam logic [5:0] POS_AFORMAT  = 6'd21;
  localparam logic [5:0] POS_CHANNELS = 6'd23;
  localparam logic [5:0] POS_RATE     = 6'd27;
  localparam logic [5:0] POS_BYTERATE = 6'd31;
  localparam logic [5:0] POS_ALIGN    = 6'd33;
  localparam logic [5:0] POS_BITS     = 6'd35;
  localparam logic [5:0] POS_DATA_TAG = 6'd39;
  localparam logic [5:0] POS_LAST     = 6'd43;

  // Little-endian tags as they sit in the byte collector
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [23:0] TAG_FMT  = 24'h74_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
  localparam logic [15:0] AFORMAT_PCM  = 16'd1;

  // Verdict codes, in header order but for bits, which come before byte rate and align
  localparam logic [3:0] ST_GOOD      = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_RIFF      = 4'd2;
  localparam logic [3:0] ST_CHUNK     = 4'd3;
  localparam logic [3:0] ST_WAVE      = 4'd4;
  localparam logic [3:0] ST_FMT       = 4'd5;
  localparam logic [3:0] ST_FMT_SIZE  = 4'd6;
  localparam logic [3:0] ST_AFORMAT   = 4'd7;
  localparam logic [3:0] ST_CHANNELS  = 4'd8;
  localparam logic [3:0] ST_RATE      = 4'd9;
  localparam logic [3:0] ST_BITS      = 4'd10;
  localparam logic [3:0] ST_BYTERATE  = 4'd11;
  localparam logic [3:0] ST_ALIGN     = 4'd12;
  localparam logic [3:0] ST_DATA_TAG  = 4'd13;
  localparam logic [3:0] ST_DATA_SIZE = 4'd14;

  // Configuration register index
  localparam logic REG_TOTAL_FILE_BYTES = 1'b0;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_DATA,
    MODE_IDLE
  } mode_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_beat_t;

  typedef struct packed {
    logic        is_header_result;
    logic [3:0]  status;
    logic        padded;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
    logic [7:0]  payload_byte;
    logic        last;
  } out_beat_t;

endpackage

// ===== hw/rtl/pcm_wav_header_checker.sv =====
// PCM WAV header checker. Bytes of a WAV file enter one per beat on the input
// channel; first_byte restarts the parse (after reset the block already waits
// at header offset zero). The 44-byte header is checked in file order against
// total_file_bytes (APB register at address 0; the user must write it only
// while the block is idle, which the block does not enforce) and one verdict
// beat comes out on its last byte, carrying the first failing check (0 good,
// 1 short file, 2..14 in header order but bits (10) before byte rate (11) and
// align (12)), the padded flag and the channel count, sample rate, bits per
// sample and data size. A file shorter than 44 bytes gets its verdict on the
// first byte. After a good verdict the data bytes pass through, the last one
// marked; a trailing pad byte and anything after a failing verdict are
// swallowed until the next first_byte. Throughput is one byte per clock unless
// the output stalls: each byte is registered, run through one pass of compare
// logic and lands in the output register; input ready follows output ready.
module pcm_wav_header_checker (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pwhc_pkg::in_beat_t  in_data_i,

  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pwhc_pkg::out_beat_t out_data_o,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Config register
  logic [31:0] file_bytes_q, file_bytes_d;
  logic        reg_hit;

  // Input stage
  logic               in_valid_q, in_valid_d;
  pwhc_pkg::in_beat_t in_q, in_d;

  // Output stage
  logic                out_valid_q, out_valid_d;
  pwhc_pkg::out_beat_t out_q, out_d;

  // Parser hookup
  logic                advance;
  logic                res_valid;
  pwhc_pkg::out_beat_t res;

  // APB: one 32-bit register, index taken from paddr[2]
  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == pwhc_pkg::REG_TOTAL_FILE_BYTES;
  assign prdata  = reg_hit ? file_bytes_q : 32'd0;

  always_comb begin
    file_bytes_d = file_bytes_q;
    if (psel && penable && pwrite && reg_hit) begin
      file_bytes_d = pwdata;
    end
  end

  // A registered beat is consumed when the output register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      in_d       = in_data_i;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  pwhc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .beat_i       (in_q),
    .file_bytes_i (file_bytes_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      // advance implies the output register is empty or being taken now
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_bytes_q <= 32'd0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      file_bytes_q <= file_bytes_d;
      in_valid_q   <= in_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

endmodule

// ===== hw/rtl/pwhc_parser.sv =====
module pwhc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pwhc_pkg::in_beat_t  beat_i,
  input  logic [31:0]         file_bytes_i,
  output logic                res_valid_o,
  output pwhc_pkg::out_beat_t res_o
);

  logic [5:0]            pos_q, pos_d;
  pwhc_pkg::mode_e       mode_q, mode_d;
  logic [3:0]            err_q, err_d;
  logic [31:0]           shift_q, shift_d;
  logic [15:0]           ch_q, ch_d;
  logic [31:0]           rate_q, rate_d;
  logic [31:0]           brate_q, brate_d;
  logic [15:0]           align_q, align_d;
  logic [15:0]           bits_q, bits_d;
  logic [31:0]           remain_q, remain_d;

  // State as seen after a first-byte restart
  logic [5:0]            pos_eff;
  pwhc_pkg::mode_e       mode_eff;
  logic [3:0]            err_eff;
  logic [31:0]           shift_prev;
  logic [31:0]           shift_new;
  logic                  short_file;
  logic [3:0]            err_chk;

  // Format products: channels and bits are 1/2 and 8/16 whenever they matter,
  // so frame/8 is a power of two 1, 2 or 4.
  logic [15:0]           new_bits;
  logic                  ch_ok, bits_ok;
  logic [1:0]            frame_log2;
  logic [33:0]           rate_scaled;
  logic                  fail_bits, fail_brate, fail_align;

  // Data size
  logic                  size_odd;
  logic [32:0]           size_sum;
  logic                  size_fail;
  logic                  hdr_fail;

  function automatic logic [3:0] note_error(logic [3:0] err, logic failed, logic [3:0] code);
    note_error = (failed && err == pwhc_pkg::ST_GOOD) ? code : err;
  endfunction

  assign pos_eff    = beat_i.first_byte ? 6'd0 : pos_q;
  assign mode_eff   = beat_i.first_byte ? pwhc_pkg::MODE_HEADER : mode_q;
  assign err_eff    = beat_i.first_byte ? pwhc_pkg::ST_GOOD : err_q;
  assign shift_prev = beat_i.first_byte ? 32'd0 : shift_q;
  assign shift_new  = {beat_i.data_byte, shift_prev[31:8]};
  assign short_file = (pos_eff == 6'd0) &&
                      (file_bytes_i < 32'(pwhc_pkg::HEADER_BYTES));

  assign new_bits    = shift_new[31:16];
  assign ch_ok       = (ch_q == 16'd1) || (ch_q == 16'd2);
  assign bits_ok     = (new_bits == 16'd8) || (new_bits == 16'd16);
  assign frame_log2  = {1'b0, ch_q == 16'd2} + {1'b0, new_bits == 16'd16};
  assign rate_scaled = {2'b00, rate_q} << frame_log2;
  assign fail_bits   = !bits_ok;
  assign fail_brate  = !(ch_ok && bits_ok) || (rate_scaled != {2'b00, brate_q});
  assign fail_align  = !(ch_ok && bits_ok) || (align_q != (16'd1 << frame_log2));

  assign size_odd  = shift_new[0];
  assign size_sum  = {1'b0, shift_new} + (size_odd ? 33'd45 : 33'd44);
  assign size_fail = size_sum != {1'b0, file_bytes_i};
  assign hdr_fail  = err_chk != pwhc_pkg::ST_GOOD;

  always_comb begin
    unique case (pos_eff)
      pwhc_pkg::POS_RIFF:
        err_chk = note_error(err_eff, shift_new != pwhc_pkg::TAG_RIFF, pwhc_pkg::ST_RIFF);
      pwhc_pkg::POS_CHUNK:
        err_chk = note_error(err_eff, ({1'b0, shift_new} + 33'd8) != {1'b0, file_bytes_i},
                             pwhc_pkg::ST_CHUNK);
      pwhc_pkg::POS_WAVE:
        err_chk = note_error(err_eff, shift_new != pwhc_pkg::TAG_WAVE, pwhc_pkg::ST_WAVE);
      pwhc_pkg::POS_FMT:
        err_chk = note_error(err_eff, shift_new[23:0] != pwhc_pkg::TAG_FMT, pwhc_pkg::ST_FMT);
      pwhc_pkg::POS_FMT_SIZE:
        err_chk = note_error(err_eff, shift_new != pwhc_pkg::FMT_SIZE_PCM,
                             pwhc_pkg::ST_FMT_SIZE);
      pwhc_pkg::POS_AFORMAT:
        err_chk = note_error(err_eff, new_bits != pwhc_pkg::AFORMAT_PCM,
                             pwhc_pkg::ST_AFORMAT);
      pwhc_pkg::POS_CHANNELS:
        err_chk = note_error(err_eff, (new_bits != 16'd1) && (new_bits != 16'd2),
                             pwhc_pkg::ST_CHANNELS);
      pwhc_pkg::POS_RATE:
        err_chk = note_error(err_eff, shift_new == 32'd0, pwhc_pkg::ST_RATE);
      pwhc_pkg::POS_BITS:
        err_chk = note_error(note_error(note_error(err_eff, fail_bits, pwhc_pkg::ST_BITS),
                                        fail_brate, pwhc_pkg::ST_BYTERATE),
                             fail_align, pwhc_pkg::ST_ALIGN);
      pwhc_pkg::POS_DATA_TAG:
        err_chk = note_error(err_eff, shift_new != pwhc_pkg::TAG_DATA, pwhc_pkg::ST_DATA_TAG);
      pwhc_pkg::POS_LAST:
        err_chk = note_error(err_eff, size_fail, pwhc_pkg::ST_DATA_SIZE);
      default:
        err_chk = err_eff;
    endcase
  end

  // Next state
  always_comb begin
    pos_d    = pos_q;
    mode_d   = mode_q;
    err_d    = err_q;
    shift_d  = shift_q;
    ch_d     = ch_q;
    rate_d   = rate_q;
    brate_d  = brate_q;
    align_d  = align_q;
    bits_d   = bits_q;
    remain_d = remain_q;
    if (step_i) begin
      pos_d   = pos_eff;
      mode_d  = mode_eff;
      err_d   = err_eff;
      shift_d = shift_prev;
      unique case (mode_eff)
        pwhc_pkg::MODE_DATA: begin
          if (remain_q == 32'd0) begin
            mode_d = pwhc_pkg::MODE_IDLE;
          end else begin
            remain_d = remain_q - 32'd1;
            if (remain_q == 32'd1) begin
              mode_d = pwhc_pkg::MODE_IDLE;
            end
          end
        end
        pwhc_pkg::MODE_HEADER: begin
          if (short_file) begin
            mode_d = pwhc_pkg::MODE_IDLE;
          end else begin
            shift_d = shift_new;
            err_d   = err_chk;
            pos_d   = pos_eff + 6'd1;
            unique case (pos_eff)
              pwhc_pkg::POS_CHANNELS: ch_d    = new_bits;
              pwhc_pkg::POS_RATE:     rate_d  = shift_new;
              pwhc_pkg::POS_BYTERATE: brate_d = shift_new;
              pwhc_pkg::POS_ALIGN:    align_d = new_bits;
              pwhc_pkg::POS_BITS:     bits_d  = new_bits;
              pwhc_pkg::POS_LAST: begin
                pos_d    = 6'd0;
                remain_d = shift_new;
                mode_d   = (hdr_fail || shift_new == 32'd0) ? pwhc_pkg::MODE_IDLE
                                                             : pwhc_pkg::MODE_DATA;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Result
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (mode_eff)
      pwhc_pkg::MODE_DATA: begin
        res_valid_o        = remain_q != 32'd0;
        res_o.payload_byte = beat_i.data_byte;
        res_o.last         = remain_q == 32'd1;
      end
      pwhc_pkg::MODE_HEADER: begin
        if (short_file) begin
          res_valid_o            = 1'b1;
          res_o.is_header_result = 1'b1;
          res_o.status           = pwhc_pkg::ST_SHORT;
          res_o.last             = 1'b1;
        end else if (pos_eff == pwhc_pkg::POS_LAST) begin
          res_valid_o            = 1'b1;
          res_o.is_header_result = 1'b1;
          res_o.status           = err_chk;
          res_o.padded           = !hdr_fail && size_odd;
          res_o.channel_count    = ch_q;
          res_o.sample_rate      = rate_q;
          res_o.sample_bits      = bits_q;
          res_o.data_length      = shift_new;
          res_o.last             = hdr_fail || (shift_new == 32'd0);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 6'd0;
      mode_q   <= pwhc_pkg::MODE_HEADER;
      err_q    <= pwhc_pkg::ST_GOOD;
      shift_q  <= 32'd0;
      ch_q     <= 16'd0;
      rate_q   <= 32'd0;
      brate_q  <= 32'd0;
      align_q  <= 16'd0;
      bits_q   <= 16'd0;
      remain_q <= 32'd0;
    end else begin
      pos_q    <= pos_d;
      mode_q   <= mode_d;
      err_q    <= err_d;
      shift_q  <= shift_d;
      ch_q     <= ch_d;
      rate_q   <= rate_d;
      brate_q  <= brate_d;
      align_q  <= align_d;
      bits_q   <= bits_d;
      remain_q <= remain_d;
    end
  end

endmodule
